FILE: rtl/timed_history_rewind_interp_unit_defines.svh
// Assertion helpers shared by the RTL files.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef TIMED_HISTORY_REWIND_INTERP_UNIT_DEFINES_SVH
`define TIMED_HISTORY_REWIND_INTERP_UNIT_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define THRI_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("thri assertion failed");

// Checks that a condition is followed by another in the next cycle.
`define THRI_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("thri assertion failed");

`endif

FILE: rtl/thri_pkg.sv
package thri_pkg;

  // One input item.
  typedef struct packed {
    logic               func;
    logic        [31:0] stamp;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic               found;
    logic        [31:0] out_stamp;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  // One stored history frame.
  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } frame_t;

  // Operation codes of the func field.
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // Fraction format: unsigned Q1.16, with one as the clamp value.
  localparam int unsigned FRAC_BITS = 16;
  localparam logic [16:0] FRAC_ONE  = 17'h10000;

  // Divider control and status.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_ctl_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quo;
  } div_stat_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIM,
    ST_Q_OLD,
    ST_Q_WALK,
    ST_Q_SPAN,
    ST_Q_DIV,
    ST_Q_MUL,
    ST_Q_ADD,
    ST_Q_PUT
  } eng_state_t;

endpackage

FILE: rtl/thri_queue.sv
module thri_queue
  import thri_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     item_valid,
  output logic     item_is_query,
  output in_item_t item,
  input  logic     item_pop
);

  in_item_t   q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  // Two-entry queue between the input port and the back end.
  assign in_stall      = (cnt_r == 2'd2);
  assign push          = in_valid && !in_stall;
  assign item_valid    = (cnt_r != 2'd0);
  assign pop           = item_pop && item_valid;
  assign item          = q_r[rd_ptr_r];
  assign item_is_query = (q_r[rd_ptr_r].func == FUNC_QUERY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

FILE: rtl/thri_div.sv
module thri_div
  import thri_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_ctl_t  ctl,
  output div_stat_t stat
);

  // Restoring division of a numerator below the denominator, one
  // quotient bit per cycle, giving the 16 fraction bits of num / den.
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [15:0] quo_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] rem2;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    rem2 = {rem_r, 1'b0};
    ge   = (rem2 >= {1'b0, den_r});
    diff = rem2 - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= ctl.num;
      den_r <= ctl.den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : rem2[31:0];
      quo_r <= {quo_r[14:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quo  = quo_r;

endmodule

FILE: rtl/thri_engine.sv
`include "timed_history_rewind_interp_unit_defines.svh"

module thri_engine
  import thri_pkg::*;
#(
  parameter int unsigned D = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        item_valid,
  input  logic        item_is_query,
  input  in_item_t    item,
  output logic        item_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int unsigned AW = $clog2(D);
  localparam int unsigned CW = $clog2(D + 1);

  eng_state_t        state_r;
  eng_state_t        state_nxt;
  logic [31:0]       window_r;
  logic [AW-1:0]     newest_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     oldest_r;
  logic [AW-1:0]     walk_slot_r;
  logic [CW-1:0]     k_r;
  logic [31:0]       stamp_r;
  frame_t            mem [D];
  frame_t            rd_q_r;
  frame_t            prev_r;
  frame_t            older_r;
  frame_t            newer_r;
  logic [16:0]       f_r;
  logic signed [50:0] prod_x_r;
  logic signed [50:0] prod_y_r;
  logic signed [50:0] prod_z_r;
  out_item_t         res_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic              out_free;
  logic [AW-1:0]     newest_inc;
  logic [CW-1:0]     count_inc;
  logic [AW-1:0]     oldest_rec;
  logic signed [32:0] trim_span;
  logic              trim_drop;
  logic signed [32:0] q_span;
  logic [31:0]       q_diff;
  logic signed [32:0] d_x;
  logic signed [32:0] d_y;
  logic signed [32:0] d_z;
  logic signed [17:0] f_s;
  div_ctl_t          div_ctl;
  div_stat_t         div_st;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == AW'(D - 1)) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    return (s == '0) ? AW'(D - 1) : s - AW'(1);
  endfunction

  // Slot that lies k places older than slot n, going round the ring.
  function automatic logic [AW-1:0] slot_minus(input logic [AW-1:0] n,
                                               input logic [CW-1:0] k);
    logic [AW:0] nn;
    logic [AW:0] kk;
    logic [AW:0] r;
    nn = {1'b0, n};
    kk = (AW + 1)'(k);
    r  = (nn >= kk) ? (nn - kk) : (nn + (AW + 1)'(D) - kk);
    return r[AW-1:0];
  endfunction

  thri_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .stat (div_st)
  );

  // Arithmetic helpers for the record trim and the query.
  always_comb begin
    newest_inc = (count_r != '0) ? slot_inc(newest_r) : newest_r;
    count_inc  = (count_r == CW'(D)) ? count_r : count_r + CW'(1);
    oldest_rec = slot_minus(newest_inc, count_inc - CW'(1));
    trim_span  = $signed({1'b0, stamp_r}) - $signed({1'b0, rd_q_r.t});
    trim_drop  = trim_span > $signed({1'b0, window_r});
    q_span     = $signed({1'b0, newer_r.t}) - $signed({1'b0, older_r.t});
    q_diff     = stamp_r - older_r.t;
    d_x        = $signed({newer_r.x[31], newer_r.x}) - $signed({older_r.x[31], older_r.x});
    d_y        = $signed({newer_r.y[31], newer_r.y}) - $signed({older_r.y[31], older_r.y});
    d_z        = $signed({newer_r.z[31], newer_r.z}) - $signed({older_r.z[31], older_r.z});
    f_s        = $signed({1'b0, f_r});
    out_free   = !out_valid_r || !out_stall;
  end

  // Sequencer: next state and control strobes.
  always_comb begin
    state_nxt = state_r;
    item_pop  = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = newest_r;
    div_ctl   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          if (!item_is_query) begin
            mem_we = 1'b1;
            if (count_inc > CW'(1)) begin
              rd_en     = 1'b1;
              rd_addr   = oldest_rec;
              state_nxt = ST_TRIM;
            end
          end else if (count_r == '0) begin
            state_nxt = ST_Q_PUT;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = slot_minus(newest_r, count_r - CW'(1));
            state_nxt = ST_Q_OLD;
          end
        end
      end
      ST_TRIM: begin
        state_nxt = ST_IDLE;
        if (trim_drop && count_r > CW'(2)) begin
          rd_en     = 1'b1;
          rd_addr   = slot_inc(oldest_r);
          state_nxt = ST_TRIM;
        end
      end
      ST_Q_OLD: begin
        if (rd_q_r.t > stamp_r) begin
          state_nxt = ST_Q_PUT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = newest_r;
          state_nxt = ST_Q_WALK;
        end
      end
      ST_Q_WALK: begin
        if (rd_q_r.t <= stamp_r) begin
          state_nxt = ST_Q_SPAN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = slot_dec(walk_slot_r);
        end
      end
      ST_Q_SPAN: begin
        if (q_span <= 33'sd0) begin
          state_nxt = ST_Q_PUT;
        end else if ($signed({1'b0, q_diff}) >= q_span) begin
          state_nxt = ST_Q_MUL;
        end else begin
          div_ctl.start = 1'b1;
          div_ctl.num   = q_diff;
          div_ctl.den   = q_span[31:0];
          state_nxt     = ST_Q_DIV;
        end
      end
      ST_Q_DIV: begin
        if (div_st.done) begin
          state_nxt = ST_Q_MUL;
        end
      end
      ST_Q_MUL: state_nxt = ST_Q_ADD;
      ST_Q_ADD: state_nxt = ST_Q_PUT;
      ST_Q_PUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers: window, ring pointers, result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= 32'd4000;
      newest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      if (state_r == ST_IDLE && mem_we) begin
        newest_r <= newest_inc;
        count_r  <= count_inc;
      end else if (state_r == ST_TRIM && trim_drop) begin
        count_r <= count_r - CW'(1);
      end
      if (state_r == ST_Q_PUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // History store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[newest_inc] <= '{t: item.stamp, x: item.pos_x, y: item.pos_y, z: item.pos_z};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Datapath registers of the trim and the query.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        stamp_r  <= item.stamp;
        oldest_r <= oldest_rec;
        res_r    <= '0;
      end
      ST_TRIM: begin
        if (trim_drop) begin
          oldest_r <= slot_inc(oldest_r);
        end
      end
      ST_Q_OLD: begin
        k_r         <= '0;
        walk_slot_r <= newest_r;
      end
      ST_Q_WALK: begin
        if (rd_q_r.t <= stamp_r) begin
          older_r <= rd_q_r;
          newer_r <= (k_r == '0) ? rd_q_r : prev_r;
        end else begin
          prev_r      <= rd_q_r;
          k_r         <= k_r + CW'(1);
          walk_slot_r <= slot_dec(walk_slot_r);
        end
      end
      ST_Q_SPAN: begin
        f_r <= FRAC_ONE;
        if (q_span <= 33'sd0) begin
          res_r <= '{found: 1'b1, out_stamp: older_r.t, out_x: older_r.x,
                     out_y: older_r.y, out_z: older_r.z};
        end
      end
      ST_Q_DIV: begin
        if (div_st.done) begin
          f_r <= {1'b0, div_st.quo};
        end
      end
      ST_Q_MUL: begin
        prod_x_r <= d_x * f_s;
        prod_y_r <= d_y * f_s;
        prod_z_r <= d_z * f_s;
      end
      ST_Q_ADD: begin
        // Arithmetic shift floors the scaled difference.
        res_r <= '{found: 1'b1, out_stamp: stamp_r,
                   out_x: older_r.x + prod_x_r[47:16],
                   out_y: older_r.y + prod_y_r[47:16],
                   out_z: older_r.z + prod_z_r[47:16]};
      end
      ST_Q_PUT: begin
        if (out_free) begin
          out_data_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `THRI_ASSERT_ALWAYS(a_count_max, count_r <= CW'(D))
  `THRI_ASSERT_ALWAYS(a_walk_bound, state_r != ST_Q_WALK || k_r < count_r)
  `THRI_ASSERT_ALWAYS(a_trim_count, state_r != ST_TRIM || count_r > CW'(1))
  `THRI_ASSERT_NEXT(a_div_to_mul, state_r == ST_Q_DIV && div_st.done, state_r == ST_Q_MUL)

endmodule

FILE: rtl/timed_history_rewind_interp_unit.sv
// History of timestamped positions with rewind by linear interpolation.
// Input channel (in_valid / in_stall / in_data): a record item stores a
// frame and returns nothing; a query item returns one result on the
// output channel (out_valid / out_stall / out_data). A transfer happens
// at a clock edge with valid high and stall low.
// cfg_we / cfg_wdata write the record window; write it only while idle.
// Items enter a two-entry queue and are carried out one at a time by the
// back end. A record writes its frame, then drops the oldest frames out
// of the window, keeping at least one; a query reads the oldest frame,
// walks back from the newest (up to HISTORY_DEPTH - 1 frames), then
// divides, multiplies and adds to interpolate between the two frames.
// Results wait in an output register; while out_stall is high the result
// holds and records keep running, a later query waits for the register.
// After reset the store is empty and the window is 4000 ticks; no clearing
// pass is needed.
module timed_history_rewind_interp_unit
  import thri_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic     item_valid;
  logic     item_is_query;
  in_item_t item;
  logic     item_pop;

  // Front end: accepts and classifies items.
  thri_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .item_valid   (item_valid),
    .item_is_query(item_is_query),
    .item         (item),
    .item_pop     (item_pop)
  );

  // Back end: history store, trim and query sequencer.
  thri_engine #(
    .D(HISTORY_DEPTH)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_is_query(item_is_query),
    .item         (item),
    .item_pop     (item_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

FILE: bench/timed_history_rewind_interp_unit_test.sv
`timescale 1ns / 100ps

module timed_history_rewind_interp_unit_test;
  import thri_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned SETTLE_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  // Local copy of the history and the window.
  logic [31:0] hist_t [DEPTH];
  logic [31:0] hist_x [DEPTH];
  logic [31:0] hist_y [DEPTH];
  logic [31:0] hist_z [DEPTH];
  int unsigned head_slot;
  int unsigned held;
  logic [31:0] window_ticks;

  out_item_t   rewind_queue[$];
  int unsigned error_count = 0;
  bit          stall_quiet = 1'b0;

  timed_history_rewind_interp_unit #(.HISTORY_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic int unsigned nth_slot(int unsigned k);
    return (head_slot + DEPTH - (k % DEPTH)) % DEPTH;
  endfunction

  // Older plus floor of the scaled difference, on 64-bit signed math.
  function automatic logic [31:0] blend_axis(logic [31:0] a, logic [31:0] b,
                                             longint f);
    longint lo;
    longint p;
    longint q;
    lo = longint'(signed'(a));
    p = (longint'(signed'(b)) - lo) * f;
    if (p >= 0) q = p >>> 16;
    else q = -((-p + 65535) >>> 16);
    return 32'(lo + q);
  endfunction

  // Updates the history copy, returns the expected result of a query.
  function automatic bit predict_rewind(in_item_t it, output out_item_t res);
    int unsigned k;
    int unsigned o;
    int unsigned n;
    longint span;
    longint f;
    res = '0;
    if (it.func == FUNC_RECORD) begin
      if (held != 0) head_slot = (head_slot + 1) % DEPTH;
      hist_t[head_slot] = it.stamp;
      hist_x[head_slot] = it.pos_x;
      hist_y[head_slot] = it.pos_y;
      hist_z[head_slot] = it.pos_z;
      if (held < DEPTH) held++;
      while (held > 1) begin
        span = longint'(hist_t[nth_slot(0)]) - longint'(hist_t[nth_slot(held - 1)]);
        if (span <= longint'(window_ticks)) break;
        held--;
      end
      return 1'b0;
    end
    if (held == 0) return 1'b1;
    if (hist_t[nth_slot(held - 1)] > it.stamp) return 1'b1;
    k = 0;
    while (k < held && hist_t[nth_slot(k)] > it.stamp) k++;
    if (k >= held) return 1'b1;
    o = nth_slot(k);
    n = (k == 0) ? o : nth_slot(k - 1);
    span = longint'(hist_t[n]) - longint'(hist_t[o]);
    res.found = 1'b1;
    if (span <= 0) begin
      res.out_stamp = hist_t[o];
      res.out_x = hist_x[o];
      res.out_y = hist_y[o];
      res.out_z = hist_z[o];
    end else begin
      f = ((longint'(it.stamp) - longint'(hist_t[o])) << 16) / span;
      if (f > 65536) f = 65536;
      res.out_stamp = it.stamp;
      res.out_x = blend_axis(hist_x[o], hist_x[n], f);
      res.out_y = blend_axis(hist_y[o], hist_y[n], f);
      res.out_z = blend_axis(hist_z[o], hist_z[n], f);
    end
    return 1'b1;
  endfunction

  function automatic int unsigned gap_len();
    if (stall_quiet || $urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Sends one item and records what it should give back. Valid stays high
  // after the transfer until the next gap or until the sender goes idle.
  task automatic send_item(in_item_t it);
    out_item_t res;
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_rewind(it, res)) rewind_queue.push_back(res);
  endtask

  task automatic send_record(logic [31:0] t, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
    in_item_t it;
    it = '{func: FUNC_RECORD, stamp: t, pos_x: x, pos_y: y, pos_z: z};
    send_item(it);
  endtask

  task automatic send_query(logic [31:0] t);
    in_item_t it;
    it = '{func: FUNC_QUERY, stamp: t, pos_x: $urandom, pos_y: $urandom,
           pos_z: $urandom};
    send_item(it);
  endtask

  // Waits for the queue to drain, then for records still being trimmed.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (rewind_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] w);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    window_ticks = w;
  endtask

  // Result side: random stall and field checks against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (rewind_queue.size() == 0) begin
          $error("result transfer with nothing expected");
          error_count++;
        end else begin
          exp_res = rewind_queue.pop_front();
          if (out_data.found !== exp_res.found) begin
            $error("found: expected %0d, got %0d", exp_res.found, out_data.found);
            error_count++;
          end
          if (out_data.out_stamp !== exp_res.out_stamp) begin
            $error("out_stamp: expected %0d, got %0d", exp_res.out_stamp,
                   out_data.out_stamp);
            error_count++;
          end
          if (out_data.out_x !== exp_res.out_x) begin
            $error("out_x: expected %0d, got %0d", exp_res.out_x, out_data.out_x);
            error_count++;
          end
          if (out_data.out_y !== exp_res.out_y) begin
            $error("out_y: expected %0d, got %0d", exp_res.out_y, out_data.out_y);
            error_count++;
          end
          if (out_data.out_z !== exp_res.out_z) begin
            $error("out_z: expected %0d, got %0d", exp_res.out_z, out_data.out_z);
            error_count++;
          end
        end
      end
      if (stall_quiet) out_stall <= 1'b0;
      else if ($urandom_range(0, 49) == 0) out_stall <= 1'b1;
      else if (out_stall && $urandom_range(0, 3) == 0) out_stall <= 1'b0;
      else if (!out_stall) out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Empty store, single frame, exact and in-between times, extremes.
  task automatic test_directed();
    send_query(32'd0);
    send_query(32'hFFFF_FFFF);
    send_record(32'd100, 32'h0000_0100, 32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'd99);
    send_query(32'd100);
    send_query(32'd5000);
    send_record(32'd200, 32'hFFFF_FF00, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'd150);
    send_query(32'd101);
    send_query(32'd199);
    send_record(32'd200, 32'h1234_5678, 32'd0, 32'hFFFF_FFFF);
    send_query(32'd200);
    send_query(32'd300);
    // Out-of-order time: a newer frame older than the last.
    send_record(32'd50, 32'd7, 32'd8, 32'd9);
    send_query(32'd120);
    send_query(32'd60);
    // Window trim: a frame far in the future drops the old ones.
    send_record(32'd10000, 32'd1, 32'd2, 32'd3);
    send_query(32'd9000);
    send_query(32'd10000);
    send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
    send_query(32'hFFFF_FFFF);
    send_query(32'hFFFF_FFFE);
  endtask

  // Mostly rising times with random steps, sprinkled with queries mostly near the latest time.
  task automatic test_random(int unsigned count, logic [31:0] step_max);
    logic [31:0] clock_now;
    logic [31:0] t;
    clock_now = $urandom;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: t = $urandom;
          1: t = clock_now + $urandom_range(0, 3);
          default: t = clock_now - $urandom_range(0, step_max * 4);
        endcase
        send_query(t);
      end else begin
        case ($urandom_range(0, 9))
          0: t = $urandom;
          1: t = clock_now - $urandom_range(0, step_max);
          2: t = clock_now;
          default: t = clock_now + $urandom_range(0, step_max);
        endcase
        clock_now = t;
        send_record(t, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Full store with a large window: overwrite of the oldest frame.
  task automatic test_wraparound();
    for (int unsigned i = 0; i < DEPTH + 10; i++)
      send_record(32'd1000 + i * 3, $urandom, $urandom, $urandom);
    for (int unsigned i = 0; i < 12; i++)
      send_query(32'd1000 + $urandom_range(0, (DEPTH + 10) * 3 + 5));
  endtask

  // Sender waits until every expectation is met, with the result side quiet.
  task automatic test_hold_off();
    stall_quiet = 1'b1;
    for (int unsigned i = 0; i < 10; i++) begin
      send_record(32'd500 + i * 10, $urandom, $urandom, $urandom);
      send_query(32'd500 + $urandom_range(0, 100));
      in_valid <= 1'b0;
      while (rewind_queue.size() != 0) @(posedge clk);
    end
    stall_quiet = 1'b0;
  endtask

  initial begin
    head_slot = 0;
    held = 0;
    window_ticks = 32'd4000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_window(32'd0);
    test_random(60, 32'd50);
    write_window(32'hFFFF_FFFF);
    test_wraparound();
    test_random(100, 32'd100000);
    write_window(32'd300);
    test_random(150, 32'd40);
    test_hold_off();
    write_window(32'd4000);
    test_random(100, 32'd200);
    write_window(32'd1);
    test_random(40, 32'd2);
    drain_results();
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/thri_pkg.sv
rtl/thri_queue.sv
rtl/thri_div.sv
rtl/thri_engine.sv
rtl/timed_history_rewind_interp_unit.sv
bench/timed_history_rewind_interp_unit_test.sv
